// ===== design/bat_pkg.sv =====
package bat_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_MM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_MS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE     = 3'd5;

  localparam logic [11:0] RST_OBSTACLE_MM   = 12'd50;
  localparam logic [15:0] RST_BACK_MS       = 16'd500;
  localparam logic [15:0] RST_TURN_MS       = 16'd400;
  localparam logic [7:0]  RST_MEASURE_MS    = 8'd100;
  localparam logic [14:0] RST_FORWARD_SPEED = 15'd13107;
  localparam logic [14:0] RST_TURN_RATE     = 15'd16384;

  localparam logic [11:0] FAR_MM        = 12'd4000;
  localparam logic [7:0]  SAMPLE_MAX    = 8'd255;
  localparam logic [15:0] LFSR_SEED     = 16'hACE1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] distance_mm;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] rotation_cmd;
    logic [1:0]         mode;
    logic               active;
  } out_word_t;

  typedef struct packed {
    logic [11:0] obstacle_mm;
    logic [15:0] back_ms;
    logic [15:0] turn_ms;
    logic [7:0]  measure_ms;
    logic [14:0] forward_speed;
    logic [14:0] turn_rate;
  } cfg_t;

  typedef struct packed {
    logic        run_flag;
    mode_t       mode;
    logic [7:0]  sample_timer;
    logic [11:0] latched_distance;
    logic [15:0] linear_hold;
    logic [15:0] rotation_hold;
    logic [15:0] lfsr;
  } state_t;

endpackage

// ===== design/bat_step.sv =====
module bat_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  bat_pkg::cfg_t             cfg,
  input  bat_pkg::state_t           state,
  input  logic [TIMER_WIDTH-1:0]    mode_timer,
  input  bat_pkg::in_word_t         in_word,
  output bat_pkg::state_t           state_next,
  output logic [TIMER_WIDTH-1:0]    mode_timer_next,
  output bat_pkg::out_word_t        result
);
  import bat_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [7:0]             sample_inc;
  logic [11:0]            latched;
  logic [15:0]            fwd16;
  logic [15:0]            rate16;
  logic                   back_done;
  logic                   turn_done;
  logic                   lfsr_bit;
  logic [15:0]            lfsr_new;

  always_comb begin
    timer_inc  = (mode_timer == TIMER_MAX) ? mode_timer : mode_timer + 1'b1;
    sample_inc = (state.sample_timer == SAMPLE_MAX) ? state.sample_timer
                                                    : state.sample_timer + 8'd1;
    fwd16  = {1'b0, cfg.forward_speed};
    rate16 = {1'b0, cfg.turn_rate};
    // A saturated mode timer always counts as expired.
    back_done = (CMP_W'(timer_inc) >= CMP_W'(cfg.back_ms)) || (timer_inc == TIMER_MAX);
    turn_done = (CMP_W'(timer_inc) >= CMP_W'(cfg.turn_ms)) || (timer_inc == TIMER_MAX);
    lfsr_bit  = state.lfsr[0] ^ state.lfsr[2] ^ state.lfsr[3] ^ state.lfsr[5];
    lfsr_new  = {lfsr_bit, state.lfsr[15:1]};
    latched   = state.latched_distance;

    state_next      = state;
    mode_timer_next = mode_timer;

    case (in_word.func)
      FUNC_TICK: begin
        state_next.sample_timer = sample_inc;
        mode_timer_next         = timer_inc;
        if (state.run_flag) begin
          if ((sample_inc > cfg.measure_ms) || (sample_inc == SAMPLE_MAX)) begin
            latched = (in_word.distance_mm == 12'd0) ? FAR_MM : in_word.distance_mm;
            state_next.latched_distance = latched;
            state_next.sample_timer     = 8'd0;
          end
          case (state.mode)
            MODE_FWD: begin
              state_next.rotation_hold = 16'd0;
              if (latched < cfg.obstacle_mm) begin
                state_next.linear_hold = 16'd0;
                state_next.mode        = MODE_BACK;
                mode_timer_next        = '0;
              end else begin
                state_next.linear_hold = fwd16;
              end
            end
            MODE_BACK: begin
              if (!back_done) begin
                state_next.linear_hold   = 16'd0 - fwd16;
                state_next.rotation_hold = 16'd0;
              end else begin
                state_next.lfsr = lfsr_new;
                state_next.mode = lfsr_new[0] ? MODE_RIGHT : MODE_LEFT;
                mode_timer_next = '0;
              end
            end
            default: begin
              if (!turn_done) begin
                state_next.linear_hold   = 16'd0;
                state_next.rotation_hold = (state.mode == MODE_LEFT) ? rate16
                                                                     : 16'd0 - rate16;
              end else begin
                state_next.mode = MODE_FWD;
              end
            end
          endcase
        end
      end
      FUNC_START: begin
        state_next.run_flag = 1'b1;
        state_next.mode     = MODE_FWD;
        mode_timer_next     = '0;
      end
      FUNC_STOP: begin
        state_next.run_flag      = 1'b0;
        state_next.linear_hold   = 16'd0;
        state_next.rotation_hold = 16'd0;
      end
      default: begin
      end
    endcase

    result.linear_cmd   = $signed(state_next.linear_hold);
    result.rotation_cmd = $signed(state_next.rotation_hold);
    result.mode         = state_next.mode;
    result.active       = state_next.run_flag;
  end

endmodule

// ===== design/bump_and_turn_avoidance_fsm_top.sv =====
// Channel  | Signals                                 | Word
// ---------+-----------------------------------------+-----------------------------
// input    | in_valid, in_ready, in_word             | func, distance_mm
// output   | out_valid, out_ready, out_word          | linear_cmd, rotation_cmd, mode, active
// config   | cfg_we, cfg_index, cfg_data             | six registers, write only
//
// Each word is applied to the controller state in the cycle it is accepted, and its
// result appears in the output register on the next cycle: one word per cycle unless out_ready stalls.
// The output register frees on the same edge it is read, so input keeps flowing while
// the output side takes every result. Reset (rst, synchronous) restores the registers
// and the controller state to their defaults.
module bump_and_turn_avoidance_fsm_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bat_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bat_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [bat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bat_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bat_pkg::*;

  cfg_t                   cfg;
  state_t                 state;
  state_t                 state_next;
  logic [TIMER_WIDTH-1:0] mode_timer;
  logic [TIMER_WIDTH-1:0] mode_timer_next;
  out_word_t              result;
  logic                   in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  bat_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .cfg            (cfg),
    .state          (state),
    .mode_timer     (mode_timer),
    .in_word        (in_word),
    .state_next     (state_next),
    .mode_timer_next(mode_timer_next),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.obstacle_mm   <= RST_OBSTACLE_MM;
      cfg.back_ms       <= RST_BACK_MS;
      cfg.turn_ms       <= RST_TURN_MS;
      cfg.measure_ms    <= RST_MEASURE_MS;
      cfg.forward_speed <= RST_FORWARD_SPEED;
      cfg.turn_rate     <= RST_TURN_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBSTACLE_MM:   cfg.obstacle_mm   <= cfg_data[11:0];
        CFG_BACK_MS:       cfg.back_ms       <= cfg_data[15:0];
        CFG_TURN_MS:       cfg.turn_ms       <= cfg_data[15:0];
        CFG_MEASURE_MS:    cfg.measure_ms    <= cfg_data[7:0];
        CFG_FORWARD_SPEED: cfg.forward_speed <= cfg_data[14:0];
        CFG_TURN_RATE:     cfg.turn_rate     <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.run_flag         <= 1'b0;
      state.mode             <= MODE_FWD;
      state.sample_timer     <= SAMPLE_MAX;
      state.latched_distance <= FAR_MM;
      state.linear_hold      <= 16'd0;
      state.rotation_hold    <= 16'd0;
      state.lfsr             <= LFSR_SEED;
      mode_timer             <= '0;
      out_valid              <= 1'b0;
    end else if (in_fire) begin
      state      <= state_next;
      mode_timer <= mode_timer_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word <= result;
    end
  end

endmodule
